FILE: hdl/sllf_pkg.sv
// Shared widths, register map, reset values and controller/datapath types.
package sllf_pkg;

	localparam int NUM_FANS_DEF  = 8;
	localparam int GAIN_FRAC_DEF = 12;

	localparam int CH_W      = 3;
	localparam int RAW_W     = 16;
	localparam int TIME_W    = 32;
	localparam int RPM_W     = 24;
	localparam int SCALE_W   = 8;
	localparam int REG_W     = 16;
	localparam int DELTA_W   = RPM_W + 1;
	localparam int STEP_W    = RPM_W + 2;
	localparam int LIM_X_W   = TIME_W + 2;
	localparam int MS_PER_S  = 1000;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	// floor(x / 1000) = (x * LIM_RECIP) >> LIM_SHIFT, exact for any 32-bit x
	localparam int                     LIM_RECIP_W = 29;
	localparam logic [LIM_RECIP_W-1:0] LIM_RECIP   = 29'd274877907;
	localparam int                     LIM_SHIFT   = 38;
	localparam int                     LIM_PROD_W  = TIME_W + LIM_RECIP_W;

	localparam logic [SCALE_W-1:0] SCALE_RST = 8'd100;
	localparam logic [REG_W-1:0]   LAG_RST   = 16'd1000;
	localparam logic [REG_W-1:0]   SLEW_RST  = 16'd1500;
	localparam logic [REG_W-1:0]   RGAP_RST  = 16'd5000;
	localparam logic [REG_W-1:0]   MGAP_RST  = 16'd100;
	localparam logic [REG_W-1:0]   FLOOR_RST = 16'd50;

	typedef enum logic [2:0] {
		REG_SCALE,
		REG_LAG,
		REG_SLEW,
		REG_RGAP,
		REG_MGAP,
		REG_FLOOR
	} reg_idx_t;

	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [REG_W-1:0]   lag;
		logic [REG_W-1:0]   slew;
		logic [REG_W-1:0]   rgap;
		logic [REG_W-1:0]   mgap;
		logic [REG_W-1:0]   floor_rpm;
	} cfg_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic eval;
		logic div_start;
		logic mul;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic filt;
		logic div_busy;
		logic out_free;
	} stat_t;

endpackage

FILE: hdl/sllf_ifs.sv
// Valid/ready channel interfaces for reading words and result words.
interface sllf_in_if;
	logic                       valid;
	logic                       ready;
	logic [sllf_pkg::CH_W-1:0]   channel;
	logic [sllf_pkg::RAW_W-1:0]  raw_reading;
	logic [sllf_pkg::TIME_W-1:0] now_ms;

	modport source (output valid, output channel, output raw_reading, output now_ms,
		input ready);
	modport sink (input valid, input channel, input raw_reading, input now_ms,
		output ready);
endinterface

interface sllf_out_if;
	logic                      valid;
	logic                      ready;
	logic [sllf_pkg::RPM_W-1:0] filtered_rpm;

	modport source (output valid, output filtered_rpm, input ready);
	modport sink (input valid, input filtered_rpm, output ready);
endinterface

FILE: hdl/sllf_cfg.sv
// APB register file holding the filter configuration.
module sllf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sllf_pkg::ADDR_W-1:0]   paddr,
	input  logic [sllf_pkg::DATA_W-1:0]   pwdata,
	output logic [sllf_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output sllf_pkg::cfg_t                cfg
);
	import sllf_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale     <= SCALE_RST;
			cfg_q.lag       <= LAG_RST;
			cfg_q.slew      <= SLEW_RST;
			cfg_q.rgap      <= RGAP_RST;
			cfg_q.mgap      <= MGAP_RST;
			cfg_q.floor_rpm <= FLOOR_RST;
		end else if (wr) begin
			unique case (idx)
				REG_SCALE: cfg_q.scale     <= pwdata[SCALE_W-1:0];
				REG_LAG:   cfg_q.lag       <= pwdata[REG_W-1:0];
				REG_SLEW:  cfg_q.slew      <= pwdata[REG_W-1:0];
				REG_RGAP:  cfg_q.rgap      <= pwdata[REG_W-1:0];
				REG_MGAP:  cfg_q.mgap      <= pwdata[REG_W-1:0];
				REG_FLOOR: cfg_q.floor_rpm <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SCALE: prdata = DATA_W'(cfg_q.scale);
			REG_LAG:   prdata = DATA_W'(cfg_q.lag);
			REG_SLEW:  prdata = DATA_W'(cfg_q.slew);
			REG_RGAP:  prdata = DATA_W'(cfg_q.rgap);
			REG_MGAP:  prdata = DATA_W'(cfg_q.mgap);
			REG_FLOOR: prdata = DATA_W'(cfg_q.floor_rpm);
			default:   prdata = '0;
		endcase
	end

endmodule

FILE: hdl/sllf_div.sv
// Restoring divider, one quotient bit per cycle.
module sllf_div #(
	parameter int NUM_W = 28,
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quot
);
	import sllf_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W-1:0] rem_nx;

	assign trial  = {rem_q, quo_q[NUM_W-1]};
	assign ge     = trial >= {1'b0, den};
	assign rem_nx = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
	assign busy   = busy_q;
	assign quot   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

endmodule

FILE: hdl/sllf_datapath.sv
// Per-fan state, target and gap evaluation, gain and slew arithmetic, output register.
module sllf_datapath #(
	parameter int NUM_FANS       = sllf_pkg::NUM_FANS_DEF,
	parameter int GAIN_FRAC_BITS = sllf_pkg::GAIN_FRAC_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sllf_pkg::cfg_t  cfg,
	input  sllf_pkg::cmd_t  cmd,
	output sllf_pkg::stat_t st,
	sllf_in_if.sink         in_ch,
	sllf_out_if.source      out_ch
);
	import sllf_pkg::*;

	localparam int IDX_W   = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
	localparam int NUM_A_W = REG_W + GAIN_FRAC_BITS;
	localparam int DEN_A_W = REG_W + 1;
	localparam int ALPHA_W = GAIN_FRAC_BITS + 1;
	localparam int PROD_W  = DELTA_W + ALPHA_W + 1;

	typedef enum logic [2:0] {
		KIND_ZERO,
		KIND_JUMP,
		KIND_HOLD,
		KIND_TOUCH,
		KIND_FILT
	} kind_t;

	logic [RPM_W-1:0]  smooth_q [NUM_FANS];
	logic [TIME_W-1:0] last_q [NUM_FANS];
	logic [NUM_FANS-1:0] seen_q;

	logic [IDX_W-1:0]  ch_mod;
	logic [IDX_W-1:0]  ch_q;
	logic [RAW_W-1:0]  raw_q;
	logic [TIME_W-1:0] now_q;

	logic [RPM_W-1:0]  target_s1;
	logic [TIME_W-1:0] dt_s1;
	logic [RPM_W-1:0]  smooth_s1;
	logic              seen_s1;

	kind_t                      kind_c;
	kind_t                      kind_q;
	logic signed [DELTA_W-1:0]  delta_s2;
	logic [REG_W-1:0]           dt_s2;
	logic [DEN_A_W-1:0]         den_s2;
	logic [TIME_W-1:0]          slew_dt_s2;

	logic [NUM_A_W-1:0]         quo_a;
	logic                       busy_a;
	logic [ALPHA_W-1:0]         alpha;
	logic [LIM_PROD_W-1:0]      lim_prod;
	logic signed [PROD_W-1:0]   prod_s3;
	logic [TIME_W-1:0]          lim_s3;

	logic signed [PROD_W-1:0]   shifted;
	logic signed [STEP_W-1:0]   step_raw;
	logic signed [STEP_W-1:0]   step_nz;
	logic [TIME_W-1:0]          lim_val;
	logic signed [LIM_X_W-1:0]  step_x;
	logic signed [LIM_X_W-1:0]  lim_x;
	logic signed [LIM_X_W-1:0]  step_cl;
	logic [RPM_W-1:0]           new_val;
	logic [RPM_W-1:0]           res_val;

	logic              out_valid_q;
	logic [RPM_W-1:0]  out_data_q;
	logic              capture;

	assign capture      = cmd.in_ready & in_ch.valid;
	assign in_ch.ready  = cmd.in_ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.filtered_rpm = out_data_q;

	assign st.in_valid = in_ch.valid;
	assign st.filt     = (kind_c == KIND_FILT);
	assign st.div_busy = busy_a;
	assign st.out_free = ~out_valid_q | out_ch.ready;

	// fold out-of-range channel codes onto the fans
	always_comb begin
		ch_mod = '0;
		for (int v = 0; v < 2 ** CH_W; v++) begin
			if (in_ch.channel == CH_W'(v)) begin
				ch_mod = IDX_W'(v % NUM_FANS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			ch_q  <= ch_mod;
			raw_q <= in_ch.raw_reading;
			now_q <= in_ch.now_ms;
		end
		if (cmd.load) begin
			target_s1 <= RPM_W'(raw_q * cfg.scale);
			dt_s1     <= now_q - last_q[ch_q];
			smooth_s1 <= smooth_q[ch_q];
			seen_s1   <= seen_q[ch_q];
		end
	end

	always_comb begin
		if (target_s1 < RPM_W'(cfg.floor_rpm)) begin
			kind_c = KIND_ZERO;
		end else if (!seen_s1 || dt_s1 > TIME_W'(cfg.rgap)) begin
			kind_c = KIND_JUMP;
		end else if (dt_s1 < TIME_W'(cfg.mgap)) begin
			kind_c = KIND_HOLD;
		end else if (target_s1 == smooth_s1) begin
			kind_c = KIND_TOUCH;
		end else begin
			kind_c = KIND_FILT;
		end
	end

	// in the filter case the gap never exceeds the reset interval, so 16 bits hold it
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			kind_q     <= kind_c;
			delta_s2   <= $signed({1'b0, target_s1}) - $signed({1'b0, smooth_s1});
			dt_s2      <= dt_s1[REG_W-1:0];
			den_s2     <= {1'b0, cfg.lag} + {1'b0, dt_s1[REG_W-1:0]};
			slew_dt_s2 <= cfg.slew * dt_s1[REG_W-1:0];
		end
	end

	sllf_div #(
		.NUM_W (NUM_A_W),
		.DEN_W (DEN_A_W)
	) u_div_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    ({dt_s2, {GAIN_FRAC_BITS{1'b0}}}),
		.den    (den_s2),
		.busy   (busy_a),
		.quot   (quo_a)
	);

	assign alpha = (den_s2 == '0) ? {1'b1, {GAIN_FRAC_BITS{1'b0}}} : quo_a[ALPHA_W-1:0];

	// slew*dt/1000 by reciprocal multiply
	assign lim_prod = {{LIM_RECIP_W{1'b0}}, slew_dt_s2} * {{TIME_W{1'b0}}, LIM_RECIP};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s3 <= delta_s2 * $signed({1'b0, alpha});
			lim_s3  <= TIME_W'(lim_prod[LIM_PROD_W-1:LIM_SHIFT]);
		end
	end

	// arithmetic shift floors; step magnitude never exceeds the delta
	always_comb begin
		shifted  = prod_s3 >>> GAIN_FRAC_BITS;
		step_raw = shifted[STEP_W-1:0];
		if (step_raw == '0) begin
			step_nz = delta_s2[DELTA_W-1] ? '1 : STEP_W'(1);
		end else begin
			step_nz = step_raw;
		end
		lim_val = (lim_s3 == '0) ? TIME_W'(1) : lim_s3;
		step_x  = {{(LIM_X_W - STEP_W){step_nz[STEP_W-1]}}, step_nz};
		lim_x   = $signed({2'b00, lim_val});
		if (step_x > lim_x) begin
			step_cl = lim_x;
		end else if (step_x < -lim_x) begin
			step_cl = -lim_x;
		end else begin
			step_cl = step_x;
		end
		new_val = smooth_s1 + step_cl[RPM_W-1:0];
	end

	always_comb begin
		case (kind_q)
			KIND_ZERO: res_val = '0;
			KIND_JUMP: res_val = target_s1;
			KIND_FILT: res_val = new_val;
			default:   res_val = smooth_s1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			for (int i = 0; i < NUM_FANS; i++) begin
				smooth_q[i] <= '0;
				last_q[i]   <= '0;
			end
		end else if (cmd.commit) begin
			case (kind_q)
				KIND_ZERO, KIND_JUMP: begin
					smooth_q[ch_q] <= res_val;
					last_q[ch_q]   <= now_q;
					seen_q[ch_q]   <= 1'b1;
				end
				KIND_TOUCH: last_q[ch_q] <= now_q;
				KIND_FILT: begin
					smooth_q[ch_q] <= res_val;
					last_q[ch_q]   <= now_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= res_val;
		end
	end

endmodule

FILE: hdl/sllf_ctrl.sv
// Sequencer for one reading: load, evaluate, divide and multiply for a filtered reading, commit.
module sllf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  sllf_pkg::stat_t st,
	output sllf_pkg::cmd_t  cmd
);
	import sllf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_EVAL,
		S_START,
		S_DIV,
		S_MUL,
		S_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (st.in_valid) state_q <= S_LOAD;
				S_LOAD:   state_q <= S_EVAL;
				S_EVAL:   state_q <= st.filt ? S_START : S_COMMIT;
				S_START:  state_q <= S_DIV;
				S_DIV:    if (!st.div_busy) state_q <= S_MUL;
				S_MUL:    state_q <= S_COMMIT;
				S_COMMIT: if (st.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.in_ready  = (state_q == S_IDLE);
		cmd.load      = (state_q == S_LOAD);
		cmd.eval      = (state_q == S_EVAL);
		cmd.div_start = (state_q == S_START);
		cmd.mul       = (state_q == S_MUL);
		cmd.commit    = (state_q == S_COMMIT) & st.out_free;
	end

endmodule

FILE: hdl/slew_limited_lag_filter.sv
// Top level of the slew-limited first-order lag filter for fan tachometer channels.
//
// Takes one reading word (channel, raw tachometer value, millisecond timestamp) at a time
// and returns one word with the channel's filtered RPM. A reading that forces zero, jumps to
// the target, falls inside the minimum gap or already matches the target passes through the
// load, evaluate and commit states to the result register, and the next word is taken once
// the controller is back in idle. A reading that runs the lag filter also passes through
// start, divide and multiply states for the bit-serial gain divide of (dt << GAIN_FRAC_BITS)
// by (tau + dt); the slew limit slew*dt/1000 comes from a reciprocal multiply. A finished
// result waits in the output register while the next reading is accepted. Registers sit at
// byte addresses 4*i and should be written only while the block is idle.
module slew_limited_lag_filter #(
	parameter int NUM_FANS       = sllf_pkg::NUM_FANS_DEF,
	parameter int GAIN_FRAC_BITS = sllf_pkg::GAIN_FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sllf_pkg::ADDR_W-1:0] paddr,
	input  logic [sllf_pkg::DATA_W-1:0] pwdata,
	output logic [sllf_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	sllf_in_if.sink                     in_ch,
	sllf_out_if.source                  out_ch
);
	import sllf_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	sllf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sllf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd)
	);

	sllf_datapath #(
		.NUM_FANS       (NUM_FANS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.st     (st),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule
